// ----- design/gyro_heading_hold_pd_drive_assert.svh -----
// Assertion macros shared by the heading-hold drive RTL.
`ifndef GYRO_HEADING_HOLD_PD_DRIVE_ASSERT_SVH
`define GYRO_HEADING_HOLD_PD_DRIVE_ASSERT_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define GHHPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define GHHPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ghhpd_pkg.sv -----
// Types and constants for the gyro heading-hold PD drive.
package ghhpd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_TARGET_SPEED  = 3'd0;
   localparam logic [2:0] REG_RUN_TICKS     = 3'd1;
   localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
   localparam logic [2:0] REG_DERIV_GAIN    = 3'd3;
   localparam logic [2:0] REG_SMOOTH_FACTOR = 3'd4;

   // Command codes carried in tuser of the request channel.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // Register reset values.
   localparam logic [14:0] TARGET_SPEED_RST  = 15'd0;
   localparam logic [15:0] RUN_TICKS_RST     = 16'd0;
   localparam logic [23:0] PROP_GAIN_RST     = 24'd5033;
   localparam logic [23:0] DERIV_GAIN_RST    = 24'd16777;
   localparam logic [24:0] SMOOTH_FACTOR_RST = 25'd13421773;

   // Fixed point: one in Q.24 and the mask of the fraction bits.
   localparam logic [24:0] Q_ONE       = 25'h100_0000;
   localparam logic [23:0] Q_FRAC_MASK = 24'hFF_FFFF;

   localparam logic signed [31:0] HEADING_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] HEADING_MIN = 32'sh8000_0000;
   localparam logic signed [15:0] WHEEL_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] WHEEL_MIN   = 16'sh8000;

   // Result queue depth and pointer width.
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_PTR_W = 3;

   typedef struct packed {
      logic               done;
      logic signed [15:0] right_speed;
      logic signed [15:0] left_speed;
   } rsp_item_type;

endpackage

// ----- design/gyro_heading_hold_pd_drive.sv -----
// Pipeline: a result passes through stages s1..s3 into the queue after its request
// transfer, and is offered on the result channel once it is written there.
// Throughput: one request per cycle while req_tready is high; heading, error and ramp
// state update in the accept cycle, so the rate is set by that loop and the 8-entry queue.
// The PD operands are split at bit 17 into partial products over two pipeline stages.
// Reset is synchronous: run state clears, registers return to defaults, queue empties.
module gyro_heading_hold_pd_drive (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] gyro_rate
   input  logic        req_tuser,   // [0] command
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_speed, [31:16] right_speed
   output logic        rsp_tuser,   // [0] done_res
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [24:0] csr_wdata
);

   // Configuration registers.
   logic [14:0] target_speed_ff;
   logic [15:0] run_ticks_ff;
   logic [23:0] prop_gain_ff;
   logic [23:0] deriv_gain_ff;
   logic [24:0] smooth_factor_ff;

   // Run state.
   logic signed [31:0] heading_ff, heading_in;
   logic signed [31:0] last_error_ff, last_error_in;
   logic [39:0]        ramp_ff, ramp_in;
   logic [15:0]        tick_ff, tick_in;
   logic               running_ff, running_in;

   // Stage 1: error terms and ramp.
   logic               s1_valid_ff;
   logic               s1_active_ff, s1_active_in;
   logic               s1_done_ff, s1_done_in;
   logic signed [32:0] s1_err_ff, s1_err_in;
   logic signed [33:0] s1_delta_ff, s1_delta_in;
   logic [39:0]        s1_ramp_ff;

   // Stage 2: partial products.
   logic               s2_valid_ff;
   logic               s2_active_ff;
   logic               s2_done_ff;
   logic signed [40:0] s2_pe_hi_ff, s2_pe_hi_in;
   logic [40:0]        s2_pe_lo_ff, s2_pe_lo_in;
   logic signed [41:0] s2_pd_hi_ff, s2_pd_hi_in;
   logic [40:0]        s2_pd_lo_ff, s2_pd_lo_in;
   logic [39:0]        s2_ramp_ff;

   // Stage 3: correction.
   logic               s3_valid_ff;
   logic               s3_active_ff;
   logic               s3_done_ff;
   logic signed [59:0] s3_corr_ff, s3_corr_in;
   logic [39:0]        s3_ramp_ff;

   // Result queue.
   ghhpd_pkg::rsp_item_type rsp_mem_ff [ghhpd_pkg::RSP_DEPTH];
   ghhpd_pkg::rsp_item_type rsp_item_in;
   ghhpd_pkg::rsp_item_type rsp_head;
   logic [ghhpd_pkg::RSP_PTR_W:0] wr_ptr_ff, rd_ptr_ff;
   logic [ghhpd_pkg::RSP_PTR_W:0] inflight_ff, inflight_in;

   logic req_fire, rsp_fire;

   // Combinational working values of the accept cycle.
   logic signed [15:0] gyro;
   logic signed [32:0] heading_sum;
   logic signed [31:0] heading_sat;
   logic signed [32:0] err;
   logic               start_ok;
   logic [24:0]        ks_sat;
   logic [24:0]        ks_comp;
   logic [39:0]        ramp_base;
   logic [44:0]        ramp_mul_hi, ramp_mul_lo;
   logic [65:0]        ramp_scaled;
   logic [39:0]        ramp_next;
   logic signed [60:0] q_left, q_right;

   // Truncate a Q.24 value toward zero and saturate to 16-bit signed.
   function automatic logic signed [15:0] wheel_value(input logic signed [60:0] q);
      logic signed [60:0] q_adj;
      logic signed [36:0] v;
      logic signed [15:0] r;
      q_adj = q[60] ? (q + 61'(ghhpd_pkg::Q_FRAC_MASK)) : q;
      v = 37'(q_adj >>> 24);
      if (v > 37'(ghhpd_pkg::WHEEL_MAX)) begin
         r = ghhpd_pkg::WHEEL_MAX;
      end else if (v < 37'(ghhpd_pkg::WHEEL_MIN)) begin
         r = ghhpd_pkg::WHEEL_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign req_tready = ~inflight_ff[ghhpd_pkg::RSP_PTR_W];
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   // Heading integration, error and smoothed speed for a tick.
   always_comb begin
      gyro        = $signed(req_tdata);
      heading_sum = 33'(heading_ff) + 33'(gyro);
      if (heading_sum[32] != heading_sum[31]) begin
         heading_sat = heading_sum[32] ? ghhpd_pkg::HEADING_MIN : ghhpd_pkg::HEADING_MAX;
      end else begin
         heading_sat = heading_sum[31:0];
      end
      // The error of the most negative heading is one past the 32-bit range.
      err         = -(33'(heading_sat));
      s1_err_in   = err;
      s1_delta_in = 34'(err) - 34'(last_error_ff);

      ks_sat      = smooth_factor_ff[24] ? ghhpd_pkg::Q_ONE : smooth_factor_ff;
      ks_comp     = ghhpd_pkg::Q_ONE - ks_sat;
      ramp_base   = 40'(target_speed_ff) * 40'(ks_comp);
      ramp_mul_hi = 45'(ks_sat) * 45'(ramp_ff[39:20]);
      ramp_mul_lo = 45'(ks_sat) * 45'(ramp_ff[19:0]);
      ramp_scaled = (66'(ramp_mul_hi) << 20) + 66'(ramp_mul_lo);
      // The target term is already in Q.24, so only the product is truncated.
      ramp_next   = ramp_base + ramp_scaled[63:24];

      start_ok    = (target_speed_ff != '0) && (run_ticks_ff != '0);
   end

   // Run state update on each request transfer.
   always_comb begin
      heading_in    = heading_ff;
      last_error_in = last_error_ff;
      ramp_in       = ramp_ff;
      tick_in       = tick_ff;
      running_in    = running_ff;
      s1_active_in  = 1'b0;
      s1_done_in    = 1'b1;
      if (req_fire) begin
         priority if (req_tuser == ghhpd_pkg::CMD_START) begin
            heading_in    = '0;
            last_error_in = '0;
            ramp_in       = '0;
            tick_in       = '0;
            running_in    = start_ok;
            s1_done_in    = ~start_ok;
         end else if (!running_ff || (tick_ff >= run_ticks_ff)) begin
            running_in = 1'b0;
         end else begin
            heading_in    = heading_sat;
            last_error_in = err[32] ? err[31:0] :
                            ((err[31] != 1'b0) ? ghhpd_pkg::HEADING_MAX : err[31:0]);
            ramp_in       = ramp_next;
            tick_in       = tick_ff + 16'd1;
            s1_active_in  = 1'b1;
            s1_done_in    = 1'b0;
         end
      end
   end

   // Partial products of the PD terms, and the correction sum.
   always_comb begin
      s2_pe_hi_in = 41'($signed(s1_err_ff[32:17])) * 41'($signed({1'b0, prop_gain_ff}));
      s2_pe_lo_in = 41'(s1_err_ff[16:0]) * 41'(prop_gain_ff);
      s2_pd_hi_in = 42'($signed(s1_delta_ff[33:17])) * 42'($signed({1'b0, deriv_gain_ff}));
      s2_pd_lo_in = 41'(s1_delta_ff[16:0]) * 41'(deriv_gain_ff);
      s3_corr_in  = (60'(s2_pe_hi_ff) <<< 17) + 60'(s2_pe_lo_ff)
                  + (60'(s2_pd_hi_ff) <<< 17) + 60'(s2_pd_lo_ff);
   end

   // Wheel values into the result queue.
   always_comb begin
      q_left  = 61'(s3_ramp_ff) - 61'(s3_corr_ff);
      q_right = 61'(s3_ramp_ff) + 61'(s3_corr_ff);
      rsp_item_in.done = s3_done_ff;
      if (s3_active_ff) begin
         rsp_item_in.left_speed  = wheel_value(q_left);
         rsp_item_in.right_speed = wheel_value(q_right);
      end else begin
         rsp_item_in.left_speed  = '0;
         rsp_item_in.right_speed = '0;
      end
   end

   assign inflight_in = inflight_ff + (req_fire ? 4'd1 : 4'd0) - (rsp_fire ? 4'd1 : 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_speed_ff  <= ghhpd_pkg::TARGET_SPEED_RST;
         run_ticks_ff     <= ghhpd_pkg::RUN_TICKS_RST;
         prop_gain_ff     <= ghhpd_pkg::PROP_GAIN_RST;
         deriv_gain_ff    <= ghhpd_pkg::DERIV_GAIN_RST;
         smooth_factor_ff <= ghhpd_pkg::SMOOTH_FACTOR_RST;
         heading_ff       <= '0;
         last_error_ff    <= '0;
         ramp_ff          <= '0;
         tick_ff          <= '0;
         running_ff       <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         inflight_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               ghhpd_pkg::REG_TARGET_SPEED:  target_speed_ff  <= csr_wdata[14:0];
               ghhpd_pkg::REG_RUN_TICKS:     run_ticks_ff     <= csr_wdata[15:0];
               ghhpd_pkg::REG_PROP_GAIN:     prop_gain_ff     <= csr_wdata[23:0];
               ghhpd_pkg::REG_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata[23:0];
               ghhpd_pkg::REG_SMOOTH_FACTOR: smooth_factor_ff <= csr_wdata;
               default: ;
            endcase
         end
         heading_ff    <= heading_in;
         last_error_ff <= last_error_in;
         ramp_ff       <= ramp_in;
         tick_ff       <= tick_in;
         running_ff    <= running_in;
         s1_valid_ff   <= req_fire;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 4'd1;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 4'd1;
         end
         inflight_ff <= inflight_in;
      end
   end

   // Pipeline payload; the valid bits above qualify it.
   always_ff @(posedge clock) begin
      s1_active_ff <= s1_active_in;
      s1_done_ff   <= s1_done_in;
      s1_err_ff    <= s1_err_in;
      s1_delta_ff  <= s1_delta_in;
      s1_ramp_ff   <= ramp_next;
      s2_active_ff <= s1_active_ff;
      s2_done_ff   <= s1_done_ff;
      s2_pe_hi_ff  <= s2_pe_hi_in;
      s2_pe_lo_ff  <= s2_pe_lo_in;
      s2_pd_hi_ff  <= s2_pd_hi_in;
      s2_pd_lo_ff  <= s2_pd_lo_in;
      s2_ramp_ff   <= s1_ramp_ff;
      s3_active_ff <= s2_active_ff;
      s3_done_ff   <= s2_done_ff;
      s3_corr_ff   <= s3_corr_in;
      s3_ramp_ff   <= s2_ramp_ff;
      if (s3_valid_ff) begin
         rsp_mem_ff[wr_ptr_ff[ghhpd_pkg::RSP_PTR_W-1:0]] <= rsp_item_in;
      end
   end

   assign rsp_head   = rsp_mem_ff[rd_ptr_ff[ghhpd_pkg::RSP_PTR_W-1:0]];
   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_tdata  = {rsp_head.right_speed, rsp_head.left_speed};
   assign rsp_tuser  = rsp_head.done;

`include "gyro_heading_hold_pd_drive_assert.svh"

   // The queue never holds more results than there are requests in flight.
   `GHHPD_ASSERT_NOW(a_queue_within_credit, 1'b1, (wr_ptr_ff - rd_ptr_ff) <= inflight_ff, "result queue holds more than in flight")
   // Requests in flight never exceed the queue depth.
   `GHHPD_ASSERT_NOW(a_credit_bound, 1'b1, inflight_ff <= 4'd8, "in-flight count beyond queue depth")
   // A finished or idle result always carries zero speeds.
   `GHHPD_ASSERT_NOW(a_done_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 32'd0, "done result with nonzero speeds")
   // A start transfer clears the run state.
   `GHHPD_ASSERT_NEXT(a_start_clears, req_fire && (req_tuser == ghhpd_pkg::CMD_START), (tick_ff == 16'd0) && (heading_ff == 32'sd0) && (ramp_ff == 40'd0), "start did not clear run state")

endmodule
